[rtl/cgc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgc_pkg: shared types, constants and font ROM for the character generator
// Payload structs of both channels, the command word that travels between
// the front and back halves, and the 8x8 glyph table.
// ----------------------------------------------------------------------------
package cgc_pkg;

  localparam int unsigned GlyphW     = 5;
  localparam int unsigned StepW      = 4;
  localparam int unsigned QDepth     = 2;
  localparam int unsigned QPtrW      = 1;
  localparam int unsigned QCountW    = 2;

  localparam logic [GlyphW-1:0] GlyphPeriod = 5'd26;
  localparam logic [GlyphW-1:0] GlyphBlank  = 5'd27;

  localparam logic [7:0] CharUpperA = 8'd65;
  localparam logic [7:0] CharUpperZ = 8'd90;
  localparam logic [7:0] CharLowerA = 8'd97;
  localparam logic [7:0] CharLowerZ = 8'd122;
  localparam logic [7:0] CharPeriod = 8'd46;

  // last beat index of a character in each mode
  localparam logic [StepW-1:0] LastStepHor  = 4'd7;
  localparam logic [StepW-1:0] LastStepVert = 4'd8;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic [7:0] column_bits;
    logic       last_of_char;
    logic       end_of_message;
  } out_t;

  typedef struct packed {
    logic [GlyphW-1:0] glyph_idx;
    logic              last_char;
    logic              vertical;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef logic [7:0][7:0] glyph_t;

  function automatic logic [GlyphW-1:0] glyph_index(input logic [7:0] c);
    logic [GlyphW-1:0] idx;
    idx = GlyphBlank;
    if (c >= CharUpperA && c <= CharUpperZ) begin
      idx = GlyphW'(c - CharUpperA);
    end else if (c >= CharLowerA && c <= CharLowerZ) begin
      idx = GlyphW'(c - CharLowerA);
    end else if (c == CharPeriod) begin
      idx = GlyphPeriod;
    end
    return idx;
  endfunction

  // byte 0 first, byte 7 last
  function automatic glyph_t pack8(input logic [7:0] b0, input logic [7:0] b1,
                                   input logic [7:0] b2, input logic [7:0] b3,
                                   input logic [7:0] b4, input logic [7:0] b5,
                                   input logic [7:0] b6, input logic [7:0] b7);
    return {b7, b6, b5, b4, b3, b2, b1, b0};
  endfunction

  function automatic glyph_t glyph_bits(input logic [GlyphW-1:0] idx);
    glyph_t g;
    case (idx)
      5'd0:  g = pack8(8'd128, 8'd252, 8'd146, 8'd17,  8'd146, 8'd252, 8'd128, 8'd0);
      5'd1:  g = pack8(8'd129, 8'd255, 8'd137, 8'd137, 8'd141, 8'd138, 8'd112, 8'd0);
      5'd2:  g = pack8(8'd60,  8'd66,  8'd129, 8'd129, 8'd129, 8'd66,  8'd231, 8'd0);
      5'd3:  g = pack8(8'd129, 8'd255, 8'd129, 8'd129, 8'd129, 8'd66,  8'd60,  8'd0);
      5'd4:  g = pack8(8'd129, 8'd255, 8'd137, 8'd137, 8'd137, 8'd129, 8'd195, 8'd0);
      5'd5:  g = pack8(8'd129, 8'd255, 8'd145, 8'd17,  8'd57,  8'd1,   8'd7,   8'd0);
      5'd6:  g = pack8(8'd60,  8'd66,  8'd129, 8'd153, 8'd137, 8'd137, 8'd123, 8'd0);
      5'd7:  g = pack8(8'd129, 8'd255, 8'd137, 8'd8,   8'd137, 8'd255, 8'd129, 8'd0);
      5'd8:  g = pack8(8'd129, 8'd129, 8'd129, 8'd255, 8'd129, 8'd129, 8'd129, 8'd0);
      5'd9:  g = pack8(8'd112, 8'd72,  8'd129, 8'd129, 8'd127, 8'd1,   8'd1,   8'd0);
      5'd10: g = pack8(8'd129, 8'd255, 8'd137, 8'd8,   8'd149, 8'd227, 8'd129, 8'd0);
      5'd11: g = pack8(8'd129, 8'd255, 8'd129, 8'd128, 8'd128, 8'd128, 8'd192, 8'd0);
      5'd12: g = pack8(8'd129, 8'd255, 8'd130, 8'd12,  8'd130, 8'd255, 8'd129, 8'd0);
      5'd13: g = pack8(8'd129, 8'd255, 8'd130, 8'd12,  8'd145, 8'd255, 8'd129, 8'd0);
      5'd14: g = pack8(8'd60,  8'd66,  8'd129, 8'd129, 8'd129, 8'd66,  8'd60,  8'd0);
      5'd15: g = pack8(8'd129, 8'd255, 8'd137, 8'd9,   8'd9,   8'd9,   8'd6,   8'd0);
      5'd16: g = pack8(8'd62,  8'd65,  8'd65,  8'd225, 8'd65,  8'd65,  8'd62,  8'd0);
      5'd17: g = pack8(8'd129, 8'd255, 8'd137, 8'd25,  8'd169, 8'd201, 8'd134, 8'd0);
      5'd18: g = pack8(8'd230, 8'd73,  8'd137, 8'd137, 8'd137, 8'd146, 8'd103, 8'd0);
      5'd19: g = pack8(8'd3,   8'd1,   8'd129, 8'd255, 8'd129, 8'd1,   8'd3,   8'd0);
      5'd20: g = pack8(8'd1,   8'd127, 8'd129, 8'd128, 8'd129, 8'd127, 8'd1,   8'd0);
      5'd21: g = pack8(8'd1,   8'd63,  8'd65,  8'd128, 8'd65,  8'd63,  8'd1,   8'd0);
      5'd22: g = pack8(8'd1,   8'd127, 8'd129, 8'd112, 8'd129, 8'd127, 8'd1,   8'd0);
      5'd23: g = pack8(8'd129, 8'd195, 8'd165, 8'd24,  8'd165, 8'd195, 8'd129, 8'd0);
      5'd24: g = pack8(8'd1,   8'd7,   8'd137, 8'd240, 8'd137, 8'd7,   8'd1,   8'd0);
      5'd25: g = pack8(8'd195, 8'd161, 8'd145, 8'd137, 8'd137, 8'd133, 8'd195, 8'd0);
      5'd26: g = pack8(8'd192, 8'd192, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

[rtl/cgc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgc_front: input acceptance and character classification
// Holds the mode register, folds each byte onto a glyph index and pushes
// a command into the queue.
// ----------------------------------------------------------------------------
module cgc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic            cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cgc_pkg::in_t    in_data_i,
  input  cgc_pkg::q_stat_t q_stat_i,
  output logic            push_o,
  output cgc_pkg::cmd_t   cmd_o,
  output logic            vertical_o
);

  logic mode_q, mode_d;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_stat_i.full;
  assign push_o      = in_valid_i && in_ready_o;

  always_comb begin
    mode_d = mode_q;
    if (cfg_valid_i) begin
      mode_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
    end
  end

  always_comb begin
    cmd_o.glyph_idx = cgc_pkg::glyph_index(in_data_i.char_code);
    cmd_o.last_char = in_data_i.last_char;
    cmd_o.vertical  = mode_q;
  end

  assign vertical_o = mode_q;

endmodule

[rtl/cgc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgc_queue: two-entry command queue
// Decouples the classifier from the column sequencer.
// ----------------------------------------------------------------------------
module cgc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cgc_pkg::cmd_t    cmd_i,
  input  logic             pop_i,
  output cgc_pkg::cmd_t    head_o,
  output cgc_pkg::q_stat_t stat_o
);

  cgc_pkg::cmd_t entry_q [cgc_pkg::QDepth];

  logic [cgc_pkg::QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [cgc_pkg::QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [cgc_pkg::QCountW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign head_o       = entry_q[rd_ptr_q];
  assign stat_o.full  = (count_q == cgc_pkg::QCountW'(cgc_pkg::QDepth));
  assign stat_o.empty = (count_q == '0);

endmodule

[rtl/cgc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgc_back: column sequencer
// Loads a glyph from the font ROM, steps through its columns or rotated
// rows one a cycle while not stalled and drives the registered output stage.
// ----------------------------------------------------------------------------
module cgc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cgc_pkg::cmd_t    head_i,
  input  cgc_pkg::q_stat_t q_stat_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cgc_pkg::out_t    out_data_o
);

  logic                      busy_q, busy_d;
  logic [cgc_pkg::StepW-1:0] step_q, step_d;
  cgc_pkg::glyph_t           glyph_q;
  logic                      vert_q;
  logic                      last_q;
  logic                      out_valid_q, out_valid_d;
  cgc_pkg::out_t             out_q;

  logic          advance;
  logic          emit;
  logic          final_beat;
  logic [7:0]    rot_row;
  cgc_pkg::out_t beat;

  assign advance    = !out_valid_q || out_ready_i;
  assign emit       = busy_q && advance;
  assign final_beat = vert_q ? (step_q == cgc_pkg::LastStepVert)
                             : (step_q == cgc_pkg::LastStepHor);
  assign pop_o      = !q_stat_i.empty && (!busy_q || (emit && final_beat));

  // rotated row k: bit l comes from glyph byte 7-l, bit k
  always_comb begin
    for (int l = 0; l < 8; l++) begin
      rot_row[l] = glyph_q[7-l][step_q[2:0]];
    end
  end

  always_comb begin
    beat.last_of_char   = final_beat;
    beat.end_of_message = final_beat && last_q;
    if (!vert_q) begin
      beat.column_bits = glyph_q[step_q[2:0]];
    end else if (final_beat) begin
      beat.column_bits = '0;
    end else begin
      beat.column_bits = rot_row;
    end
  end

  always_comb begin
    busy_d      = busy_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (pop_o) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (emit) begin
      step_d = step_q + 1'b1;
      if (final_beat) begin
        busy_d = 1'b0;
      end
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (advance) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      glyph_q <= cgc_pkg::glyph_bits(head_i.glyph_idx);
      vert_q  <= head_i.vertical;
      last_q  <= head_i.last_char;
    end
    if (emit) begin
      out_q <= beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/char_to_glyph_columns.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_to_glyph_columns: 8x8 character generator for a scrolling LED sign
// Maps each message byte to a font glyph and streams its columns, or its
// rotated rows plus a blank spacer row in vertical mode.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  cfg      in   cfg_valid_i/cfg_ready_o  cfg_data_i   (vertical_mode)
//  in       in   in_valid_i/in_ready_o    in_data_i    (cgc_pkg::in_t)
//  out      out  out_valid_o/out_ready_i  out_data_o   (cgc_pkg::out_t)
//
//  Each character yields 8 columns (horizontal) or 9 rows (vertical), emitted
//  by the back-end sequencer one per cycle while the output is not stalled.
//  An accepted byte passes the queue entry, the glyph register and the output register in turn.
//  A two-entry queue lets the front accept while the sequencer is busy.
//  Reset clears the mode to horizontal and empties the queue.
//  An output stall holds the sequencer; the input stalls once the queue fills.
// ----------------------------------------------------------------------------
module char_to_glyph_columns (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cgc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cgc_pkg::out_t out_data_o
);

  cgc_pkg::q_stat_t q_stat;
  cgc_pkg::cmd_t    push_cmd;
  cgc_pkg::cmd_t    head_cmd;
  logic             push;
  logic             pop;
  logic             vertical;

  cgc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .cmd_o       (push_cmd),
    .vertical_o  (vertical)
  );

  cgc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .head_o (head_cmd),
    .stat_o (q_stat)
  );

  cgc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_eom_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.end_of_message |-> out_data_o.last_of_char)
    else $error("end_of_message without last_of_char");

  a_spacer_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last_of_char && vertical |-> out_data_o.column_bits == 8'd0)
    else $error("vertical spacer row not blank");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !q_stat.empty)
    else $error("accepted transaction missing from queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");
`endif

endmodule

[dv/glyph_stream_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_stream_checker: column predictor and scoreboard for the glyph streamer
// Watches the mode, character and column channels. Each accepted character is
// expanded into the columns or rotated rows the block must emit, and each
// accepted column is checked field by field against the oldest one waiting.
// ----------------------------------------------------------------------------
module glyph_stream_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  input  logic           cfg_ready_i,
  input  logic           cfg_data_i,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  cgc_pkg::in_t   in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  cgc_pkg::out_t  out_data_i,
  output int             fail_count_o,
  output int             pending_o
);

  localparam logic [7:0] UpperA      = 8'd65;
  localparam logic [7:0] UpperZ      = 8'd90;
  localparam logic [7:0] LowerA      = 8'd97;
  localparam logic [7:0] LowerZ      = 8'd122;
  localparam logic [7:0] AsciiPeriod = 8'd46;
  localparam int         GlyphDot    = 26;
  localparam int         GlyphSpace  = 27;

  logic          vertical_q = 1'b0;
  cgc_pkg::out_t column_q[$];
  cgc_pkg::out_t want;
  int            fails = 0;
  int            pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  // byte 0 lands in the low eight bits
  function automatic logic [63:0] bytes8(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] b3,
                                         input logic [7:0] b4, input logic [7:0] b5,
                                         input logic [7:0] b6, input logic [7:0] b7);
    return {b7, b6, b5, b4, b3, b2, b1, b0};
  endfunction

  function automatic logic [63:0] font_glyph(input int idx);
    logic [63:0] g;
    case (idx)
      0:  g = bytes8(8'd128, 8'd252, 8'd146, 8'd17,  8'd146, 8'd252, 8'd128, 8'd0);
      1:  g = bytes8(8'd129, 8'd255, 8'd137, 8'd137, 8'd141, 8'd138, 8'd112, 8'd0);
      2:  g = bytes8(8'd60,  8'd66,  8'd129, 8'd129, 8'd129, 8'd66,  8'd231, 8'd0);
      3:  g = bytes8(8'd129, 8'd255, 8'd129, 8'd129, 8'd129, 8'd66,  8'd60,  8'd0);
      4:  g = bytes8(8'd129, 8'd255, 8'd137, 8'd137, 8'd137, 8'd129, 8'd195, 8'd0);
      5:  g = bytes8(8'd129, 8'd255, 8'd145, 8'd17,  8'd57,  8'd1,   8'd7,   8'd0);
      6:  g = bytes8(8'd60,  8'd66,  8'd129, 8'd153, 8'd137, 8'd137, 8'd123, 8'd0);
      7:  g = bytes8(8'd129, 8'd255, 8'd137, 8'd8,   8'd137, 8'd255, 8'd129, 8'd0);
      8:  g = bytes8(8'd129, 8'd129, 8'd129, 8'd255, 8'd129, 8'd129, 8'd129, 8'd0);
      9:  g = bytes8(8'd112, 8'd72,  8'd129, 8'd129, 8'd127, 8'd1,   8'd1,   8'd0);
      10: g = bytes8(8'd129, 8'd255, 8'd137, 8'd8,   8'd149, 8'd227, 8'd129, 8'd0);
      11: g = bytes8(8'd129, 8'd255, 8'd129, 8'd128, 8'd128, 8'd128, 8'd192, 8'd0);
      12: g = bytes8(8'd129, 8'd255, 8'd130, 8'd12,  8'd130, 8'd255, 8'd129, 8'd0);
      13: g = bytes8(8'd129, 8'd255, 8'd130, 8'd12,  8'd145, 8'd255, 8'd129, 8'd0);
      14: g = bytes8(8'd60,  8'd66,  8'd129, 8'd129, 8'd129, 8'd66,  8'd60,  8'd0);
      15: g = bytes8(8'd129, 8'd255, 8'd137, 8'd9,   8'd9,   8'd9,   8'd6,   8'd0);
      16: g = bytes8(8'd62,  8'd65,  8'd65,  8'd225, 8'd65,  8'd65,  8'd62,  8'd0);
      17: g = bytes8(8'd129, 8'd255, 8'd137, 8'd25,  8'd169, 8'd201, 8'd134, 8'd0);
      18: g = bytes8(8'd230, 8'd73,  8'd137, 8'd137, 8'd137, 8'd146, 8'd103, 8'd0);
      19: g = bytes8(8'd3,   8'd1,   8'd129, 8'd255, 8'd129, 8'd1,   8'd3,   8'd0);
      20: g = bytes8(8'd1,   8'd127, 8'd129, 8'd128, 8'd129, 8'd127, 8'd1,   8'd0);
      21: g = bytes8(8'd1,   8'd63,  8'd65,  8'd128, 8'd65,  8'd63,  8'd1,   8'd0);
      22: g = bytes8(8'd1,   8'd127, 8'd129, 8'd112, 8'd129, 8'd127, 8'd1,   8'd0);
      23: g = bytes8(8'd129, 8'd195, 8'd165, 8'd24,  8'd165, 8'd195, 8'd129, 8'd0);
      24: g = bytes8(8'd1,   8'd7,   8'd137, 8'd240, 8'd137, 8'd7,   8'd1,   8'd0);
      25: g = bytes8(8'd195, 8'd161, 8'd145, 8'd137, 8'd137, 8'd133, 8'd195, 8'd0);
      26: g = bytes8(8'd192, 8'd192, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
      default: g = '0;
    endcase
    return g;
  endfunction

  // queue every result one character must produce
  function automatic void predict_char(input cgc_pkg::in_t item, input logic vert);
    int            idx;
    logic [63:0]   g;
    logic [7:0]    row;
    cgc_pkg::out_t beat;
    idx = GlyphSpace;
    if (item.char_code >= UpperA && item.char_code <= UpperZ) begin
      idx = int'(item.char_code - UpperA);
    end else if (item.char_code >= LowerA && item.char_code <= LowerZ) begin
      idx = int'(item.char_code - LowerA);
    end else if (item.char_code == AsciiPeriod) begin
      idx = GlyphDot;
    end
    g = font_glyph(idx);
    if (!vert) begin
      for (int k = 0; k < 8; k++) begin
        beat.column_bits    = g[8*k +: 8];
        beat.last_of_char   = (k == 7);
        beat.end_of_message = (k == 7) && item.last_char;
        column_q.push_back(beat);
      end
    end else begin
      for (int k = 0; k < 8; k++) begin
        for (int l = 0; l < 8; l++) begin
          row[l] = g[8*(7-l) + k];
        end
        beat.column_bits    = row;
        beat.last_of_char   = 1'b0;
        beat.end_of_message = 1'b0;
        column_q.push_back(beat);
      end
      // blank spacer row closes the character
      beat.column_bits    = '0;
      beat.last_of_char   = 1'b1;
      beat.end_of_message = item.last_char;
      column_q.push_back(beat);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertical_q = 1'b0;
      column_q.delete();
      pending = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (column_q.size() == 0) begin
          $error("column_bits: expected no transaction, actual %0d",
                 out_data_i.column_bits);
          fails++;
        end else begin
          want = column_q.pop_front();
          if (out_data_i.column_bits !== want.column_bits) begin
            $error("column_bits: expected %0d, actual %0d",
                   want.column_bits, out_data_i.column_bits);
            fails++;
          end
          if (out_data_i.last_of_char !== want.last_of_char) begin
            $error("last_of_char: expected %0d, actual %0d",
                   want.last_of_char, out_data_i.last_of_char);
            fails++;
          end
          if (out_data_i.end_of_message !== want.end_of_message) begin
            $error("end_of_message: expected %0d, actual %0d",
                   want.end_of_message, out_data_i.end_of_message);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_char(in_data_i, vertical_q);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        vertical_q = cfg_data_i;
      end
      pending = column_q.size();
    end
  end

endmodule

[dv/char_to_glyph_columns_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_to_glyph_columns_test: stimulus and verdict for the glyph streamer
// Sends message bytes in random bursts over both modes, stalls the column
// channel on its own pattern and reports the checker's outcome.
// ----------------------------------------------------------------------------
module char_to_glyph_columns_test;

  localparam int          PhaseItems = 80;
  localparam int          Phases     = 4;
  localparam int unsigned StallFrom  = 200;
  localparam int unsigned StallLen   = 150;

  logic          clk;
  logic          rst_n;
  logic          cfg_valid;
  logic          cfg_ready;
  logic          cfg_data;
  logic          in_valid;
  logic          in_ready;
  cgc_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  cgc_pkg::out_t out_data;
  int            fail_count;
  int            pending;

  char_to_glyph_columns uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  glyph_stream_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic logic [7:0] pick_code();
    int unsigned sel;
    logic [7:0]  code;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2: code = 8'($urandom_range(cgc_pkg::CharUpperA, cgc_pkg::CharUpperZ));
      3, 4, 5: code = 8'($urandom_range(cgc_pkg::CharLowerA, cgc_pkg::CharLowerZ));
      6:       code = cgc_pkg::CharPeriod;
      7:       code = 8'($urandom_range(128, 255));
      8: begin
        // bytes just outside the letter ranges
        case ($urandom_range(0, 3))
          0:       code = cgc_pkg::CharUpperA - 8'd1;
          1:       code = cgc_pkg::CharUpperZ + 8'd1;
          2:       code = cgc_pkg::CharLowerA - 8'd1;
          default: code = cgc_pkg::CharLowerZ + 8'd1;
        endcase
      end
      default: code = 8'($urandom_range(0, 255));
    endcase
    return code;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic [7:0] code, input logic is_last);
    in_valid          = 1'b1;
    in_data.char_code = code;
    in_data.last_char = is_last;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_mode(input logic mode);
    cfg_valid = 1'b1;
    cfg_data  = mode;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin : stimulus
    int burst;
    int gap;
    int sent;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);
    for (int ph = 0; ph < Phases; ph++) begin
      // switch mode only with nothing in flight
      if (ph != 0) begin
        write_mode(ph[0]);
      end
      sent = 0;
      while (sent < PhaseItems) begin
        burst = int'($urandom_range(1, 12));
        for (int b = 0; b < burst && sent < PhaseItems; b++) begin
          send_item(pick_code(), ($urandom_range(0, 5) == 0) || (sent == PhaseItems - 1));
          sent++;
        end
        gap = int'($urandom_range(0, 6));
        repeat (gap) @(negedge clk);
      end
      drain();
    end
    repeat (5) @(negedge clk);
    if (fail_count == 0) begin
      $display("** char_to_glyph_columns: PASSED **");
    end else begin
      $display("** char_to_glyph_columns: FAILED **");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned cyc;
    cyc       = 0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc >= StallFrom && cyc < StallFrom + StallLen) begin
        // hold off long enough to fill the queue and stall the input
        out_ready = 1'b0;
      end else begin
        out_ready = ((cyc % 13) != 4) && ((cyc % 5) != 0) && ($urandom_range(0, 7) != 0);
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("** char_to_glyph_columns: FAILED **");
    $finish;
  end

endmodule
